[rtl/core/xdz_pkg.sv]
`timescale 1ns / 1ps

package xdz_pkg;

    // Encoding constants
    localparam logic [7:0]  ZERO_MARKER = 8'h00;
    localparam logic [7:0]  RUN_LIMIT   = 8'hFF;
    localparam logic [15:0] CAP_RESET   = 16'd1400;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;
    localparam logic [QCNT_W-1:0] QROOM_MAX = QCNT_W'(QDEPTH - 3);

    // One encoded result
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        overflow;
        logic [15:0] total_length;
    } res_t;

    // Results of one request, written to the queue together
    typedef struct packed {
        logic [1:0]       n;
        res_t [2:0]       res;
    } enc_t;

endpackage

[rtl/core/xor_delta_zero_rle_encoder_unit.sv]
`timescale 1ns / 1ps
// Flow: an accepted request is held in the input register until the queue has
//   room, then encoded and written to the result queue; its first result is
//   offered on the output from the queue head.
// Throughput: one request per cycle while the queue has room; sustained rate is
//   bound by the one-byte result port, as a request yields 0 to 3 results.
// Reset (rst_n low, asynchronous): frame state and queue cleared, capacity 1400.

module xor_delta_zero_rle_encoder_unit
    import xdz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  prev_byte,
    input  logic [7:0]  curr_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        overflow,
    output logic [15:0] total_length
);

    logic [15:0] cap_reg;
    logic        in_vld_reg;
    logic [7:0]  x_reg;
    logic        last_reg;
    logic        accept;
    logic        adv;
    logic        room;
    logic        pop;
    enc_t        enc;
    enc_t        push;
    res_t        head;

    assign cfg_ready = 1'b1;
    assign adv       = in_vld_reg && room;
    assign in_stall  = in_vld_reg && !room;
    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Input register: hold request until the queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= prev_byte ^ curr_byte;
            last_reg <= frame_last;
        end
    end

    xdz_encode u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .x     (x_reg),
        .last  (last_reg),
        .cap   (cap_reg),
        .enc   (enc)
    );

    // Push results only on an encode step
    always_comb
    begin
        push = enc;
        if (!adv)
        begin
            push.n = 2'd0;
        end
    end

    xdz_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign out_byte     = head.out_byte;
    assign frame_end    = head.frame_end;
    assign overflow     = head.overflow;
    assign total_length = head.total_length;

endmodule

[rtl/core/xdz_encode.sv]
`timescale 1ns / 1ps

module xdz_encode
    import xdz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [7:0]  x,
    input  logic        last,
    input  logic [15:0] cap,
    output enc_t        enc
);

    logic [7:0]  zero_run_reg;
    logic [7:0]  zero_run_next;
    logic [15:0] bytes_emitted_reg;
    logic [15:0] bytes_emitted_next;
    logic        dropping_reg;
    logic        dropping_next;

    logic [7:0]  run_inc;
    logic [16:0] be_ext;
    logic [16:0] cap_ext;
    logic        fit1;
    logic        fit2;
    logic        fit3;
    logic        ok;
    logic [15:0] be_new;
    res_t        ovf_res;

    // Capacity checks for one, two and three more bytes
    assign run_inc = zero_run_reg + 8'd1;
    assign be_ext  = {1'b0, bytes_emitted_reg};
    assign cap_ext = {1'b0, cap};
    assign fit1    = (be_ext + 17'd1) <= cap_ext;
    assign fit2    = (be_ext + 17'd2) <= cap_ext;
    assign fit3    = (be_ext + 17'd3) <= cap_ext;
    assign ovf_res = '{out_byte: ZERO_MARKER, frame_end: 1'b1, overflow: 1'b1,
                       total_length: 16'd0};

    // Build the results and the next frame state
    always_comb
    begin
        enc            = '0;
        ok             = 1'b1;
        be_new         = bytes_emitted_reg;
        zero_run_next  = zero_run_reg;
        dropping_next  = dropping_reg;
        bytes_emitted_next = bytes_emitted_reg;
        if (dropping_reg)
        begin
            if (last)
            begin
                zero_run_next      = 8'd0;
                bytes_emitted_next = 16'd0;
                dropping_next      = 1'b0;
            end
        end
        else
        begin
            if (x == 8'd0)
            begin
                if ((run_inc == RUN_LIMIT) || last)
                begin
                    zero_run_next = 8'd0;
                    if (fit2)
                    begin
                        enc.res[0].out_byte = ZERO_MARKER;
                        enc.res[1].out_byte = run_inc;
                        enc.n  = 2'd2;
                        be_new = bytes_emitted_reg + 16'd2;
                    end
                    else
                    begin
                        enc.res[0] = ovf_res;
                        enc.n = 2'd1;
                        ok    = 1'b0;
                    end
                end
                else
                begin
                    zero_run_next = run_inc;
                end
            end
            else
            begin
                zero_run_next = 8'd0;
                if (zero_run_reg != 8'd0)
                begin
                    if (!fit2)
                    begin
                        enc.res[0] = ovf_res;
                        enc.n = 2'd1;
                        ok    = 1'b0;
                    end
                    else
                    begin
                        enc.res[0].out_byte = ZERO_MARKER;
                        enc.res[1].out_byte = zero_run_reg;
                        enc.n = 2'd3;
                        if (fit3)
                        begin
                            enc.res[2].out_byte = x;
                            be_new = bytes_emitted_reg + 16'd3;
                        end
                        else
                        begin
                            enc.res[2] = ovf_res;
                            be_new = bytes_emitted_reg + 16'd2;
                            ok     = 1'b0;
                        end
                    end
                end
                else if (fit1)
                begin
                    enc.res[0].out_byte = x;
                    enc.n  = 2'd1;
                    be_new = bytes_emitted_reg + 16'd1;
                end
                else
                begin
                    enc.res[0] = ovf_res;
                    enc.n = 2'd1;
                    ok    = 1'b0;
                end
            end

            bytes_emitted_next = be_new;

            // Tag the frame's final byte, or arm the drop
            if (last)
            begin
                if (ok)
                begin
                    case (enc.n)
                        2'd1:
                        begin
                            enc.res[0].frame_end    = 1'b1;
                            enc.res[0].total_length = be_new;
                        end
                        2'd2:
                        begin
                            enc.res[1].frame_end    = 1'b1;
                            enc.res[1].total_length = be_new;
                        end
                        2'd3:
                        begin
                            enc.res[2].frame_end    = 1'b1;
                            enc.res[2].total_length = be_new;
                        end
                        default:
                        begin
                            enc.res[0].frame_end = 1'b0;
                        end
                    endcase
                end
                zero_run_next      = 8'd0;
                bytes_emitted_next = 16'd0;
                dropping_next      = 1'b0;
            end
            else if (!ok)
            begin
                dropping_next = 1'b1;
            end
        end
    end

    // Hold frame state; advance on each encoded request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg      <= 8'd0;
            bytes_emitted_reg <= 16'd0;
            dropping_reg      <= 1'b0;
        end
        else if (adv)
        begin
            zero_run_reg      <= zero_run_next;
            bytes_emitted_reg <= bytes_emitted_next;
            dropping_reg      <= dropping_next;
        end
    end

`ifndef SYNTHESIS
    a_drop_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> (zero_run_reg == 8'd0))
        else $error("zero run pending while dropping");

    a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg != RUN_LIMIT)
        else $error("zero run reached limit without flush");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last) |=> ((zero_run_reg == 8'd0) && (bytes_emitted_reg == 16'd0)
                           && !dropping_reg))
        else $error("frame state not cleared after final request");
`endif

endmodule

[rtl/core/xdz_queue.sv]
`timescale 1ns / 1ps

module xdz_queue
    import xdz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  enc_t        push,
    input  logic        pop,
    output logic        room,
    output logic        head_valid,
    output res_t        head
);

    res_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] tail_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign room       = count_reg <= QROOM_MAX;
    assign head_valid = count_reg != '0;
    assign head       = q_mem_reg[head_reg];
    assign count_next = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);

    // Store up to three results at the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (QCNT_W'(i) < QCNT_W'(push.n))
            begin
                q_mem_reg[tail_reg + QPTR_W'(i)] <= push.res[i];
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + QPTR_W'(push.n);
            head_reg  <= head_reg + QPTR_W'(pop);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> ((count_reg + QCNT_W'(push.n)) <= QCNT_W'(QDEPTH)))
        else $error("push without room");

    a_ovf_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.overflow) |-> (head.frame_end && (head.total_length == 16'd0)))
        else $error("overflow result not a clean frame end");
`endif

endmodule
